/* sv/pgsc_pkg.sv */
`default_nettype none
package pgsc_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_MOTION  = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_DIAG_ENABLE = 1'b0;
   localparam logic CSR_MIN_DELTA   = 1'b1;

   // Register reset values
   localparam logic       DIAG_ENABLE_RST = 1'b0;
   localparam logic [9:0] MIN_DELTA_RST   = 10'd80;

   // Direction codes
   localparam logic [2:0] DIR_UP         = 3'd0;
   localparam logic [2:0] DIR_RIGHT      = 3'd1;
   localparam logic [2:0] DIR_DOWN       = 3'd2;
   localparam logic [2:0] DIR_LEFT       = 3'd3;
   localparam logic [2:0] DIR_UP_RIGHT   = 3'd4;
   localparam logic [2:0] DIR_DOWN_RIGHT = 3'd5;
   localparam logic [2:0] DIR_DOWN_LEFT  = 3'd6;
   localparam logic [2:0] DIR_UP_LEFT    = 3'd7;

   // Field widths fixed by the item formats
   localparam int MOVE_W  = 13;
   localparam int INDEX_W = 5;
   localparam int TOTAL_W = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_READ,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear_capture;
      logic acc_add;
      logic stroke_update;
      logic walk_clear;
      logic read_issue;
      logic out_load;
   } ctrl_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic walk_last;
   } stat_type;

endpackage
`default_nettype wire

/* sv/pgsc_ctrl.sv */
`default_nettype none
module pgsc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic [1:0]          req_cmd,
   output      logic                req_tready,
   input  wire pgsc_pkg::stat_type  stat,
   output      pgsc_pkg::ctrl_type  ctrl
);

   pgsc_pkg::state_type state_ff, state_in;
   logic                armed_ff, armed_in;

   // State and armed flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgsc_pkg::ST_IDLE;
         armed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      armed_in   = armed_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pgsc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_cmd)
                  pgsc_pkg::CMD_START: begin
                     ctrl.clear_capture = 1'b1;
                     armed_in           = 1'b1;
                  end
                  pgsc_pkg::CMD_MOTION: begin
                     if (armed_ff) begin
                        ctrl.acc_add = 1'b1;
                        state_in     = pgsc_pkg::ST_CLASSIFY;
                     end
                  end
                  pgsc_pkg::CMD_RELEASE: begin
                     armed_in        = 1'b0;
                     ctrl.walk_clear = 1'b1;
                     state_in        = pgsc_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         pgsc_pkg::ST_CLASSIFY: begin
            ctrl.stroke_update = 1'b1;
            state_in           = pgsc_pkg::ST_IDLE;
         end
         pgsc_pkg::ST_READ: begin
            ctrl.read_issue = 1'b1;
            state_in        = pgsc_pkg::ST_EMIT;
         end
         pgsc_pkg::ST_EMIT: begin
            // Hold until the output register can take the item
            if (stat.out_free) begin
               ctrl.out_load = 1'b1;
               state_in = stat.walk_last ? pgsc_pkg::ST_IDLE : pgsc_pkg::ST_READ;
            end
         end
         default: state_in = pgsc_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* sv/pgsc_dpath.sv */
`default_nettype none
module pgsc_dpath #(
   parameter int MAX_STROKES = 32,
   parameter int ACC_WIDTH   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pgsc_pkg::ctrl_type            ctrl,
   output      pgsc_pkg::stat_type            stat,
   input  wire logic signed [pgsc_pkg::MOVE_W-1:0] move_x,
   input  wire logic signed [pgsc_pkg::MOVE_W-1:0] move_y,
   input  wire logic                          csr_we,
   input  wire logic                          csr_addr,
   input  wire logic [9:0]                    csr_wdata,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [2:0]                    out_code,
   output      logic [pgsc_pkg::INDEX_W-1:0]  out_index,
   output      logic [pgsc_pkg::TOTAL_W-1:0]  out_total,
   output      logic                          out_valid,
   output      logic                          out_last
);

   localparam int IDX_W = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
   localparam int CNT_W = $clog2(MAX_STROKES + 1);
   localparam int SUM_W = ACC_WIDTH + 2;

   // Configuration registers
   logic       diag_ff;
   logic [9:0] min_delta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff      <= pgsc_pkg::DIAG_ENABLE_RST;
         min_delta_ff <= pgsc_pkg::MIN_DELTA_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            pgsc_pkg::CSR_DIAG_ENABLE: diag_ff      <= csr_wdata[0];
            pgsc_pkg::CSR_MIN_DELTA:   min_delta_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturating accumulate
   logic signed [ACC_WIDTH-1:0] acc_x_ff, acc_y_ff;
   logic signed [ACC_WIDTH-1:0] sat_x, sat_y;
   logic signed [SUM_W-1:0]     sum_x, sum_y;

   function automatic logic [ACC_WIDTH-1:0] saturate(input logic [SUM_W-1:0] s);
      logic fits;
      fits = (s[SUM_W-1:ACC_WIDTH-1] == '0) || (s[SUM_W-1:ACC_WIDTH-1] == '1);
      if (fits)
         saturate = s[ACC_WIDTH-1:0];
      else if (s[SUM_W-1])
         saturate = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      else
         saturate = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   endfunction

   always_comb begin
      sum_x = {{(SUM_W-ACC_WIDTH){acc_x_ff[ACC_WIDTH-1]}}, acc_x_ff}
            + {{(SUM_W-pgsc_pkg::MOVE_W){move_x[pgsc_pkg::MOVE_W-1]}}, move_x};
      sum_y = {{(SUM_W-ACC_WIDTH){acc_y_ff[ACC_WIDTH-1]}}, acc_y_ff}
            + {{(SUM_W-pgsc_pkg::MOVE_W){move_y[pgsc_pkg::MOVE_W-1]}}, move_y};
      sat_x = saturate(sum_x);
      sat_y = saturate(sum_y);
   end

   // Classify accumulated motion into a direction
   logic [ACC_WIDTH-1:0] mag_x, mag_y, main_t, cross_t;
   logic                 big_x, big_y, use_x, use_y, dir_found;
   logic                 neg_x, neg_y;
   logic [2:0]           dir_code;

   always_comb begin
      neg_x   = acc_x_ff[ACC_WIDTH-1];
      neg_y   = acc_y_ff[ACC_WIDTH-1];
      mag_x   = neg_x ? -acc_x_ff : acc_x_ff;
      mag_y   = neg_y ? -acc_y_ff : acc_y_ff;
      main_t  = {{(ACC_WIDTH-10){1'b0}}, min_delta_ff};
      cross_t = {{(ACC_WIDTH-9){1'b0}}, min_delta_ff[9:1]};
      big_x   = mag_x > main_t;
      big_y   = mag_y > main_t;
      use_x   = big_x || (big_y && diag_ff && (mag_x > cross_t));
      use_y   = big_x ? (diag_ff && (mag_y > cross_t)) : big_y;
      dir_found = use_x || use_y;
      if (use_x && use_y) begin
         if (neg_x) dir_code = neg_y ? pgsc_pkg::DIR_UP_LEFT  : pgsc_pkg::DIR_DOWN_LEFT;
         else       dir_code = neg_y ? pgsc_pkg::DIR_UP_RIGHT : pgsc_pkg::DIR_DOWN_RIGHT;
      end else if (use_x) begin
         dir_code = neg_x ? pgsc_pkg::DIR_LEFT : pgsc_pkg::DIR_RIGHT;
      end else begin
         dir_code = neg_y ? pgsc_pkg::DIR_UP : pgsc_pkg::DIR_DOWN;
      end
   end

   // Accumulators, held direction and stroke count
   logic [2:0]       held_ff;
   logic             held_valid_ff;
   logic [CNT_W-1:0] count_ff;
   logic             new_dir, room;

   assign new_dir = dir_found && (!held_valid_ff || (dir_code != held_ff));
   assign room    = count_ff < CNT_W'(MAX_STROKES);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_capture) begin
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else if (ctrl.acc_add) begin
         acc_x_ff <= sat_x;
         acc_y_ff <= sat_y;
      end else if (ctrl.stroke_update && dir_found) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         if (new_dir) begin
            held_valid_ff <= 1'b1;
            if (room) count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.stroke_update && new_dir) held_ff <= dir_code;
   end

   // Stroke memory
   logic [2:0]       stroke_mem [MAX_STROKES];
   logic [2:0]       rd_data_ff;
   logic [CNT_W-1:0] walk_ff;

   always_ff @(posedge clock) begin
      if (ctrl.stroke_update && new_dir && room)
         stroke_mem[count_ff[IDX_W-1:0]] <= dir_code;
      if (ctrl.read_issue)
         rd_data_ff <= stroke_mem[walk_ff[IDX_W-1:0]];
   end

   // Report walk position
   logic        empty, walk_last;
   logic [31:0] walk_wide, count_wide;

   assign empty      = count_ff == '0;
   assign walk_last  = empty || ((walk_ff + CNT_W'(1)) == count_ff);
   assign walk_wide  = 32'(walk_ff);
   assign count_wide = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset || ctrl.walk_clear)
         walk_ff <= '0;
      else if (ctrl.out_load)
         walk_ff <= walk_ff + CNT_W'(1);
   end

   // Output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (ctrl.out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         out_code  <= empty ? pgsc_pkg::DIR_UP : rd_data_ff;
         out_index <= walk_wide[pgsc_pkg::INDEX_W-1:0];
         out_total <= count_wide[pgsc_pkg::TOTAL_W-1:0];
         out_valid <= !empty;
         out_last  <= walk_last;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.walk_last = walk_last;

endmodule
`default_nettype wire

/* sv/pointer_gesture_stroke_capture.sv */
`default_nettype none
// Pointer gesture stroke capture. A start item (req_tuser = 0) arms capture and
// clears the accumulators, held direction and stroke list. While armed, each motion
// item (req_tuser = 1) is added into saturating X/Y accumulators and then classified
// into one of eight directions against min_delta (cross axis min_delta/2 when
// diagonal detection is enabled); a direction differing from the held one is stored,
// up to MAX_STROKES. A release item (req_tuser = 2) disarms and reports the list, one
// result per stroke with rsp_tlast on the final one, or a single empty result with
// rsp_tuser = 0. A motion item is accumulated, then classified; a release item reads
// each reported result from stroke memory, then loads it into the output register,
// and waits while rsp_tready is held low. No item is accepted while a motion or a
// report is in progress.
// Configure only while idle.
module pointer_gesture_stroke_capture #(
   parameter int MAX_STROKES = 32,
   parameter int ACC_WIDTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // move_x[12:0], move_y[25:13], zero pad
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // stroke_code[2:0], stroke_index[7:3],
                                         // stroke_total[13:8], zero pad
   output      logic        rsp_tuser,   // stroke_valid[0]
   output      logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [9:0]  csr_wdata
);

   pgsc_pkg::ctrl_type ctrl;
   pgsc_pkg::stat_type stat;

   logic [2:0]                   out_code;
   logic [pgsc_pkg::INDEX_W-1:0] out_index;
   logic [pgsc_pkg::TOTAL_W-1:0] out_total;

   pgsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   pgsc_dpath #(
      .MAX_STROKES (MAX_STROKES),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .move_x     (req_tdata[12:0]),
      .move_y     (req_tdata[25:13]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_code   (out_code),
      .out_index  (out_index),
      .out_total  (out_total),
      .out_valid  (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {2'b00, out_total, out_index, out_code};

endmodule
`default_nettype wire
